[hdl/lfu_pkg.sv]
// Package for the LFU slot replacement unit: sizes, slot entry type and
// register codes. No dependencies; lfu_if.sv and the top level import it.
`default_nettype none
package lfu_pkg;

  localparam int SLOTS      = 32;
  localparam int ID_BITS    = 7;
  localparam int COUNT_BITS = 16;

  // Fixed field widths of the channels and the register
  localparam int ID_FIELD_W  = 7;
  localparam int CNT_FIELD_W = 16;
  localparam int OCC_FIELD_W = 6;
  localparam int ACT_W       = 6;
  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(20);

  // Derived sizes
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OCC_W = $clog2(SLOTS + 1);
  localparam int LIM_W = (OCC_W > ACT_W) ? OCC_W : ACT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ACTIVE_SLOTS = 1'b0;

  typedef struct packed {
    logic [ID_BITS-1:0]    ident;
    logic [COUNT_BITS-1:0] uses;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

[hdl/lfu_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
// Depends on lfu_pkg for the field widths.
`default_nettype none
interface lfu_in_if import lfu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ID_FIELD_W-1:0] candidate_id;

  modport source (output valid, output candidate_id, input ready);
  modport sink   (input valid, input candidate_id, output ready);
endinterface

interface lfu_out_if import lfu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   was_resident;
  logic                   evicted_valid;
  logic [ID_FIELD_W-1:0]  evicted_id;
  logic [CNT_FIELD_W-1:0] new_count;
  logic [OCC_FIELD_W-1:0] occupancy;

  modport source (output valid, output was_resident, output evicted_valid,
                  output evicted_id, output new_count, output occupancy,
                  input ready);
  modport sink   (input valid, input was_resident, input evicted_valid,
                  input evicted_id, input new_count, input occupancy,
                  output ready);
endinterface
`default_nettype wire

[hdl/lfu_slot_replacement_unit.sv]
// Top level of the LFU slot replacement unit: sequencer, slot RAM,
// APB register. Depends on lfu_pkg, lfu_if.sv and lfu_ram.
//
// Usage: each input transaction on in_ch names an identifier. The unit
// looks it up among the resident slots (oldest first). A hit bumps its use
// count (saturating); a miss evicts the least used entry (oldest among
// equals) when the set is full, closes the gap and appends the new
// identifier with count 1. One result transaction per input on out_ch.
// The slots live in one RAM read one word per cycle; a single compare
// path scans them, and the same RAM port then moves entries down.
// A hit ends the scan at its slot; a miss scans every resident entry,
// then, on a full set, moves the entries after the victim down one slot
// before the append. in_ch.ready is high only while the unit is idle, so
// an item is taken only once the last one has gone to the output register.
// The result sits in an output register; while out_ch is stalled the
// unit still accepts and processes the next item and waits to hand it
// over. Reset empties the resident set (no RAM clearing pass) and sets
// active_slots to 20. The user must write active_slots over the cfg_ APB
// port only while the unit is idle; the unit does not enforce this.
`default_nettype none
module lfu_slot_replacement_unit import lfu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lfu_in_if.sink                     in_ch,
  lfu_out_if.source                  out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ACT_W-1:0]      act_r, act_nxt;
  logic [OCC_W-1:0]      n_r, n_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [COUNT_BITS-1:0] min_r, min_nxt;
  logic [IDX_W-1:0]      vic_r, vic_nxt;
  logic [ID_BITS-1:0]    vicid_r, vicid_nxt;
  logic                  hit_r, hit_nxt;
  logic                  evv_r, evv_nxt;
  logic [ID_BITS-1:0]    evid_r, evid_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                   ov_r, ov_nxt;
  logic                   o_hit_r, o_hit_nxt;
  logic                   o_evv_r, o_evv_nxt;
  logic [ID_FIELD_W-1:0]  o_evid_r, o_evid_nxt;
  logic [CNT_FIELD_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [OCC_FIELD_W-1:0] o_occ_r, o_occ_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;

  logic [LIM_W-1:0]      act_ext, lim;
  logic [IDX_W-1:0]      last_idx;
  logic                  match, less, is_last, full;
  logic [IDX_W-1:0]      vic_sel;
  logic [COUNT_BITS-1:0] min_sel, sat_uses;
  logic [ID_BITS-1:0]    vicid_sel;
  logic                  cfg_wr, out_free;

  lfu_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Register port: one register, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign act_nxt    = (cfg_wr && cfg_paddr[2] == REG_ACTIVE_SLOTS) ?
                      cfg_pwdata[ACT_W-1:0] : act_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_SLOTS) ?
                      CFG_DATA_W'(act_r) : '0;

  // Effective limit: zero acts as one, clamp at capacity
  assign act_ext = LIM_W'(act_r);
  always_comb begin
    if (act_r == '0) begin
      lim = LIM_W'(1);
    end else if (act_ext > LIM_W'(SLOTS)) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = act_ext;
    end
  end

  // Scan compare path
  assign last_idx  = IDX_W'(n_r - OCC_W'(1));
  assign match     = ram_rdata.ident == id_r;
  assign is_last   = cur_r == last_idx;
  assign less      = (cur_r == '0) || (ram_rdata.uses < min_r);
  assign vic_sel   = less ? cur_r : vic_r;
  assign min_sel   = less ? ram_rdata.uses : min_r;
  assign vicid_sel = less ? ram_rdata.ident : vicid_r;
  assign sat_uses  = (ram_rdata.uses == COUNT_MAX) ? ram_rdata.uses :
                     ram_rdata.uses + COUNT_BITS'(1);
  assign full      = LIM_W'(n_r) >= lim;
  assign out_free  = !ov_r || out_ch.ready;

  assign in_ch.ready = state_r == S_IDLE;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    id_nxt     = id_r;
    cur_nxt    = cur_r;
    min_nxt    = min_r;
    vic_nxt    = vic_r;
    vicid_nxt  = vicid_r;
    hit_nxt    = hit_r;
    evv_nxt    = evv_r;
    evid_nxt   = evid_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_hit_nxt  = o_hit_r;
    o_evv_nxt  = o_evv_r;
    o_evid_nxt = o_evid_r;
    o_cnt_nxt  = o_cnt_r;
    o_occ_nxt  = o_occ_r;
    ram_we     = 1'b0;
    ram_waddr  = cur_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = cur_r;
    case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (in_ch.valid) begin
          id_nxt   = in_ch.candidate_id[ID_BITS-1:0];
          cur_nxt  = '0;
          hit_nxt  = 1'b0;
          evv_nxt  = 1'b0;
          evid_nxt = '0;
          cnt_nxt  = COUNT_BITS'(1);
          state_nxt = (n_r == '0) ? S_APPEND : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          // Hit: write back the bumped count
          ram_we    = 1'b1;
          ram_wdata = '{ident: ram_rdata.ident, uses: sat_uses};
          hit_nxt   = 1'b1;
          cnt_nxt   = sat_uses;
          state_nxt = S_DONE;
        end else begin
          min_nxt   = min_sel;
          vic_nxt   = vic_sel;
          vicid_nxt = vicid_sel;
          if (!is_last) begin
            ram_raddr = IDX_W'(cur_r + IDX_W'(1));
            cur_nxt   = IDX_W'(cur_r + IDX_W'(1));
          end else if (full) begin
            // Miss on a full set: evict, then close the gap
            evv_nxt  = 1'b1;
            evid_nxt = vicid_sel;
            if (vic_sel == last_idx) begin
              state_nxt = S_APPEND;
            end else begin
              ram_raddr = IDX_W'(vic_sel + IDX_W'(1));
              cur_nxt   = vic_sel;
              state_nxt = S_SHIFT;
            end
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end
      S_SHIFT: begin
        // Move entry cur+1 down to cur
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (IDX_W'(cur_r + IDX_W'(1)) == last_idx) begin
          state_nxt = S_APPEND;
        end else begin
          ram_raddr = IDX_W'(cur_r + IDX_W'(2));
          cur_nxt   = IDX_W'(cur_r + IDX_W'(1));
        end
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = evv_r ? last_idx : IDX_W'(n_r);
        ram_wdata = '{ident: id_r, uses: COUNT_BITS'(1)};
        n_nxt     = evv_r ? n_r : OCC_W'(n_r + OCC_W'(1));
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_hit_nxt  = hit_r;
          o_evv_nxt  = evv_r;
          o_evid_nxt = ID_FIELD_W'(evid_r);
          o_cnt_nxt  = CNT_FIELD_W'(cnt_r);
          o_occ_nxt  = OCC_FIELD_W'(n_r);
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      act_r   <= ACT_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      act_r   <= act_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    cur_r    <= cur_nxt;
    min_r    <= min_nxt;
    vic_r    <= vic_nxt;
    vicid_r  <= vicid_nxt;
    hit_r    <= hit_nxt;
    evv_r    <= evv_nxt;
    evid_r   <= evid_nxt;
    cnt_r    <= cnt_nxt;
    o_hit_r  <= o_hit_nxt;
    o_evv_r  <= o_evv_nxt;
    o_evid_r <= o_evid_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_occ_r  <= o_occ_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.was_resident  = o_hit_r;
  assign out_ch.evicted_valid = o_evv_r;
  assign out_ch.evicted_id    = o_evid_r;
  assign out_ch.new_count     = o_cnt_r;
  assign out_ch.occupancy     = o_occ_r;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= OCC_W'(SLOTS))
    else $error("resident count beyond capacity");

  a_rose_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (cur_r < last_idx))
    else $error("compaction write past the last resident slot");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && evv_r) |-> (!hit_r && LIM_W'(n_r) >= lim))
    else $error("eviction without a full set or on a hit");

endmodule
`default_nettype wire

[hdl/lfu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No package or module dependencies.
`default_nettype none
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
